// ----- rtl/midi_note_led_grid_macros.svh -----
// ----------------------------------------------------------------------------
// midi_note_led_grid assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef MIDI_NOTE_LED_GRID_MACROS_SVH
`define MIDI_NOTE_LED_GRID_MACROS_SVH

// same-cycle implication
`define MNLG_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MNLG_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/mnlg_pkg.sv -----
// ----------------------------------------------------------------------------
// mnlg_pkg
// Types and fixed constants of the MIDI note tracker and LED grid reader.
// ----------------------------------------------------------------------------
`default_nettype none

package mnlg_pkg;

   localparam int NOTE_COUNT = 128;
   localparam int NOTE_W     = 7;
   localparam int CHAN_COUNT = 16;
   localparam int BRIGHT_W   = 7;
   localparam int GEN_W      = 32;
   localparam int MAX_ROWS   = 6;

   // status byte high nibble
   localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
   localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
   localparam logic [3:0] KIND_CONTROL  = 4'hB;

   localparam logic [NOTE_W-1:0]   CTRL_ALL_NOTES_OFF = 7'd123;
   localparam logic [BRIGHT_W-1:0] BRIGHT_MAX         = 7'd96;

   localparam logic [7:0] LIT_RED   = 8'd32;
   localparam logic [7:0] LIT_GREEN = 8'd96;
   localparam logic [7:0] LIT_BLUE  = 8'd255;

   localparam logic OPC_UPDATE = 1'b0;
   localparam logic OPC_READ   = 1'b1;

   localparam logic CSR_BRIGHTNESS  = 1'b0;
   localparam logic CSR_DISPLAY_OFF = 1'b1;

   // base note of each grid row, top row first
   localparam logic [NOTE_W-1:0] ROW_BASE_NOTE [MAX_ROWS] =
      '{7'd64, 7'd59, 7'd55, 7'd50, 7'd45, 7'd40};

   typedef struct packed {
      logic       opcode;
      logic [7:0] midi_status;
      logic [7:0] midi_data1;
      logic [7:0] midi_data2;
      logic [6:0] pixel_index;
   } req_type;

   typedef struct packed {
      logic                handled;
      logic                lit;
      logic [7:0]          red;
      logic [7:0]          green;
      logic [7:0]          blue;
      logic [BRIGHT_W-1:0] brightness_echo;
      logic [GEN_W-1:0]    generation;
   } rsp_type;

endpackage

`default_nettype wire

// ----- rtl/midi_note_led_grid.sv -----
// ----------------------------------------------------------------------------
// midi_note_led_grid
// Tracks which MIDI channels hold each note and reads serpentine LED pixels.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item: a MIDI message update (opcode 0) or a pixel
//   read (opcode 1). An item is taken when req_valid is high and req_stall
//   is low. Every item yields exactly one rsp_* item, held until taken.
//   csr_* writes global_brightness (index 0, saturates at 96) or
//   display_off (index 1); write only while no item is in flight.
// Sequencing:
//   Note on/off, ignored messages and pixel reads first read the note
//   memory (registered read), then modify, write back and load the result
//   register. Controller 123 sweeps the whole note memory, one entry per
//   cycle.
//   A new item is taken while a finished result still waits in rsp_*.
// Reset:
//   Clears all held notes (per-entry valid bits, no clearing pass), sets
//   the generation to 1, brightness to 96, display on.
// Stall:
//   If rsp_stall holds a result, the next result parks internally and the
//   block stops taking items until the output slot frees up.
// ----------------------------------------------------------------------------
`default_nettype none
`include "midi_note_led_grid_macros.svh"

module midi_note_led_grid #(
   parameter int COLS = 16,
   parameter int ROWS = 6
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output      logic                            req_stall,
   input  wire mnlg_pkg::req_type               req_data,
   output      logic                            rsp_valid,
   input  wire logic                            rsp_stall,
   output      mnlg_pkg::rsp_type               rsp_data,
   input  wire logic                            csr_wr_en,
   input  wire logic                            csr_index,
   input  wire logic [mnlg_pkg::BRIGHT_W-1:0]   csr_wr_data
);

   import mnlg_pkg::*;

   localparam int COL_W = (COLS > 1) ? $clog2(COLS) : 1;
   localparam int SW_W  = NOTE_W + 1;

   typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_SWEEP, ST_HOLD} state_type;
   typedef enum logic [2:0] {ACT_SET, ACT_CLR, ACT_ALL, ACT_NONE, ACT_READ} act_type;

   // control
   state_type                state_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff;
   logic [GEN_W-1:0]         gen_ff, gen_in;
   logic [BRIGHT_W-1:0]      bright_ff;
   logic                     display_off_ff;
   logic [NOTE_COUNT-1:0]    vld_ff;
   logic                     sw_wr_ff;

   // datapath
   req_type                  item_ff;
   act_type                  act_ff, act_in;
   logic                     pix_ok_ff;
   logic [NOTE_W-1:0]        wa_ff;
   logic [SW_W-1:0]          sw_ff;
   rsp_type                  res_ff, res_in;

   // note memory
   logic [CHAN_COUNT-1:0]    mem [NOTE_COUNT];
   logic [CHAN_COUNT-1:0]    rd_data_ff;
   logic                     rd_vld_ff;
   logic [NOTE_W-1:0]        rd_addr;
   logic                     mem_we;
   logic [NOTE_W-1:0]        mem_waddr;
   logic [CHAN_COUNT-1:0]    mem_wdata;

   logic                     accept, slot_free, sweep_last, fin, handled, rsp_load;
   logic [CHAN_COUNT-1:0]    cur_bits, chan_bit;
   logic [3:0]               req_kind;
   logic [2:0]               pix_row;
   logic [COL_W-1:0]         pix_cpos, pix_col;
   logic [NOTE_W:0]          pix_note;
   logic                     pix_ok;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // chain index -> row, column, note; odd rows run right to left
   always_comb begin
      pix_row = '0;
      for (int k = 1; k < ROWS; k++) begin
         if (int'(req_data.pixel_index) >= k * COLS) pix_row = 3'(k);
      end
      pix_cpos = COL_W'(int'(req_data.pixel_index) - int'(pix_row) * COLS);
      pix_col  = pix_row[0] ? (COL_W'(COLS - 1) - pix_cpos) : pix_cpos;
      pix_note = {1'b0, ROW_BASE_NOTE[pix_row]} + (NOTE_W+1)'(pix_col);
      pix_ok   = (int'(req_data.pixel_index) < ROWS * COLS) && !pix_note[NOTE_W];
   end

   assign req_kind = req_data.midi_status[7:4];

   always_comb begin
      if (req_data.opcode == OPC_READ) begin
         act_in = ACT_READ;
      end else if (req_kind == KIND_NOTE_ON && req_data.midi_data2[6:0] != '0) begin
         act_in = ACT_SET;
      end else if (req_kind == KIND_NOTE_OFF || req_kind == KIND_NOTE_ON) begin
         act_in = ACT_CLR;
      end else if (req_kind == KIND_CONTROL &&
                   req_data.midi_data1[NOTE_W-1:0] == CTRL_ALL_NOTES_OFF) begin
         act_in = ACT_ALL;
      end else begin
         act_in = ACT_NONE;
      end
   end

   always_comb begin
      case (state_ff)
         ST_SWEEP: rd_addr = sw_ff[NOTE_W-1:0];
         default:  rd_addr = (req_data.opcode == OPC_READ) ? pix_note[NOTE_W-1:0]
                                                          : req_data.midi_data1[NOTE_W-1:0];
      endcase
   end

   assign cur_bits   = rd_vld_ff ? rd_data_ff : '0;
   assign chan_bit   = CHAN_COUNT'(1) << item_ff.midi_status[3:0];
   assign sweep_last = sw_ff[NOTE_W] && sw_wr_ff;
   assign fin        = (state_ff == ST_EXEC) || (state_ff == ST_SWEEP && sweep_last);

   // output register loads a finished item or the parked one
   assign rsp_load     = slot_free && (fin || state_ff == ST_HOLD);
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = wa_ff;
      mem_wdata = cur_bits & ~chan_bit;
      if (state_ff == ST_SWEEP) begin
         mem_we = sw_wr_ff;
      end else if (state_ff == ST_EXEC) begin
         case (act_ff)
            ACT_SET: begin
               mem_we    = 1'b1;
               mem_wdata = cur_bits | chan_bit;
            end
            ACT_CLR: mem_we = 1'b1;
            default: mem_we = 1'b0;
         endcase
      end
   end

   always_comb begin
      case (act_ff) inside
         ACT_SET, ACT_CLR, ACT_ALL: handled = 1'b1;
         default:                   handled = 1'b0;
      endcase
      gen_in = gen_ff + GEN_W'(fin && handled);
      res_in.handled         = handled;
      res_in.lit             = (act_ff == ACT_READ) && pix_ok_ff && !display_off_ff &&
                               (cur_bits != '0);
      res_in.red             = res_in.lit ? LIT_RED : '0;
      res_in.green           = res_in.lit ? LIT_GREEN : '0;
      res_in.blue            = res_in.lit ? LIT_BLUE : '0;
      res_in.brightness_echo = bright_ff;
      res_in.generation      = gen_in;
   end

   // note memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      rd_data_ff <= mem[rd_addr];
      rd_vld_ff  <= vld_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff   <= req_data;
         act_ff    <= act_in;
         pix_ok_ff <= pix_ok;
         wa_ff     <= rd_addr;
         sw_ff     <= '0;
      end else if (state_ff == ST_SWEEP && !sw_ff[NOTE_W]) begin
         wa_ff <= sw_ff[NOTE_W-1:0];
         sw_ff <= sw_ff + SW_W'(1);
      end
      if (fin) res_ff <= res_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         gen_ff         <= GEN_W'(1);
         bright_ff      <= BRIGHT_MAX;
         display_off_ff <= 1'b0;
         vld_ff         <= '0;
         sw_wr_ff       <= 1'b0;
      end else begin
         gen_ff       <= gen_in;
         rsp_valid_ff <= rsp_valid_in;
         if (mem_we) vld_ff[mem_waddr] <= 1'b1;

         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_BRIGHTNESS:  bright_ff <= (csr_wr_data > BRIGHT_MAX) ? BRIGHT_MAX
                                                                        : csr_wr_data;
               CSR_DISPLAY_OFF: display_off_ff <= csr_wr_data[0];
               default: ;
            endcase
         end

         // write stage of the sweep trails its read stage by one entry
         if (accept) begin
            sw_wr_ff <= 1'b0;
         end else if (state_ff == ST_SWEEP) begin
            sw_wr_ff <= !sw_ff[NOTE_W];
         end

         unique case (state_ff) inside
            ST_IDLE: begin
               if (accept) state_ff <= (act_in == ACT_ALL) ? ST_SWEEP : ST_EXEC;
            end
            ST_EXEC, ST_SWEEP: begin
               if (fin) begin
                  if (slot_free) begin
                     rsp_ff   <= res_in;
                     state_ff <= ST_IDLE;
                  end else begin
                     state_ff <= ST_HOLD;
                  end
               end
            end
            ST_HOLD: begin
               if (slot_free) begin
                  rsp_ff   <= res_ff;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   `MNLG_ASSERT_IMPL(a_gen_step, clock, reset, !$past(reset),
      gen_ff == $past(gen_ff) || gen_ff == $past(gen_ff) + 32'd1,
      "generation moved by more than one")
   `MNLG_ASSERT_IMPL(a_hold_busy, clock, reset, state_ff == ST_HOLD, rsp_valid_ff,
      "result parked while output slot free")
   `MNLG_ASSERT_IMPL(a_sweep_order, clock, reset, state_ff == ST_SWEEP && sw_wr_ff,
      sw_ff - 8'd1 == 8'(wa_ff), "sweep write does not trail read by one")
   `MNLG_ASSERT_NEXT(a_fin_idle, clock, reset, fin && slot_free,
      state_ff == ST_IDLE && rsp_valid_ff, "finished item not delivered")

endmodule

`default_nettype wire

// ----- test/midi_note_led_grid_test.sv -----
// ----------------------------------------------------------------------------
// midi_note_led_grid_test
// Self-checking bench for the MIDI note tracker and LED grid reader. Drives
// note on/off, all-notes-off and junk messages mixed with serpentine pixel
// reads, keeps its own copy of the held-note masks, generation count and
// registers, and compares every result item field by field. Sender and
// receiver idle at random, and one long output hold-off backs the block up.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_note_led_grid_test;
   import mnlg_pkg::*;

   localparam int GRID_COLS     = 16;
   localparam int GRID_ROWS     = 6;
   localparam int SETTLE_CYCLES = NOTE_COUNT + 4;
   localparam int HOLD_CYCLES   = 200;
   localparam int CHUNK_ITEMS   = 115;
   localparam int MAX_GAP       = 30;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   req_type             req_data;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   rsp_type             rsp_data;
   logic                csr_wr_en;
   logic                csr_index;
   logic [BRIGHT_W-1:0] csr_wr_data;

   // shadow of the block state
   logic [CHAN_COUNT-1:0] held_channels [NOTE_COUNT];
   logic [GEN_W-1:0]      gen_count;
   logic [BRIGHT_W-1:0]   cur_brightness;
   logic                  cur_display_off;

   rsp_type     expected_results [$];
   int unsigned req_idle_pct = 0;
   int unsigned rsp_idle_pct = 0;
   logic        hold_active  = 1'b0;
   event        hold_go;
   int          error_count  = 0;
   int          update_count = 0;
   int          read_count   = 0;
   int          handled_count = 0;
   int          lit_count    = 0;

   midi_note_led_grid #(
      .COLS(GRID_COLS),
      .ROWS(GRID_ROWS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wr_data(csr_wr_data)
   );

   always #5 clock = ~clock;

   // Applies one item to the shadow state and returns the result it yields.
   function automatic rsp_type grid_next_result(req_type item);
      rsp_type             res;
      logic [3:0]          kind;
      logic [3:0]          chan;
      logic [NOTE_W-1:0]   note;
      logic [NOTE_W-1:0]   velocity;
      int                  row;
      int                  cpos;
      int                  col;
      int                  pixel_note;
      res = '0;
      if (item.opcode == OPC_UPDATE) begin
         kind     = item.midi_status[7:4];
         chan     = item.midi_status[3:0];
         note     = item.midi_data1[NOTE_W-1:0];
         velocity = item.midi_data2[NOTE_W-1:0];
         res.handled = 1'b1;
         if (kind == KIND_NOTE_ON && velocity != '0) begin
            held_channels[note][chan] = 1'b1;
         end else if (kind == KIND_NOTE_OFF || kind == KIND_NOTE_ON) begin
            held_channels[note][chan] = 1'b0;
         end else if (kind == KIND_CONTROL && note == CTRL_ALL_NOTES_OFF) begin
            for (int n = 0; n < NOTE_COUNT; n++) held_channels[n][chan] = 1'b0;
         end else begin
            res.handled = 1'b0;
         end
         if (res.handled) gen_count = gen_count + 1'b1;
      end else if (!cur_display_off && item.pixel_index < GRID_ROWS * GRID_COLS) begin
         row  = item.pixel_index / GRID_COLS;
         cpos = item.pixel_index % GRID_COLS;
         // odd rows run right to left
         col  = (row % 2 == 1) ? GRID_COLS - 1 - cpos : cpos;
         pixel_note = ROW_BASE_NOTE[row] + col;
         if (pixel_note < NOTE_COUNT) res.lit = held_channels[pixel_note] != '0;
      end
      res.red             = res.lit ? LIT_RED : 8'd0;
      res.green           = res.lit ? LIT_GREEN : 8'd0;
      res.blue            = res.lit ? LIT_BLUE : 8'd0;
      res.brightness_echo = cur_brightness;
      res.generation      = gen_count;
      return res;
   endfunction

   function automatic req_type make_update(logic [7:0] status, logic [7:0] d1,
                                           logic [7:0] d2);
      req_type item;
      item             = $urandom;
      item.opcode      = OPC_UPDATE;
      item.midi_status = status;
      item.midi_data1  = d1;
      item.midi_data2  = d2;
      return item;
   endfunction

   function automatic req_type make_read(logic [6:0] index);
      req_type item;
      item             = $urandom;
      item.opcode      = OPC_READ;
      item.pixel_index = index;
      return item;
   endfunction

   // Mostly well-formed note traffic aimed at the notes on the grid.
   function automatic req_type random_item();
      req_type           item;
      int unsigned       pick;
      logic [3:0]        chan;
      logic [NOTE_W-1:0] note;
      item = $urandom;
      pick = $urandom_range(99);
      chan = 4'($urandom_range(15));
      note = ($urandom_range(9) == 0) ? NOTE_W'($urandom_range(127))
                                      : NOTE_W'($urandom_range(79, 40));
      if (pick < 38) begin
         item.opcode      = OPC_READ;
         item.pixel_index = ($urandom_range(9) == 0) ? 7'($urandom_range(127))
                            : 7'($urandom_range(GRID_ROWS * GRID_COLS - 1));
      end else begin
         item.opcode = OPC_UPDATE;
         if (pick < 62) begin
            item.midi_status = {KIND_NOTE_ON, chan};
            item.midi_data1  = {1'($urandom), note};
            item.midi_data2  = ($urandom_range(6) == 0) ? {1'($urandom), 7'd0}
                               : {1'($urandom), 7'($urandom_range(127, 1))};
         end else if (pick < 80) begin
            item.midi_status = {KIND_NOTE_OFF, chan};
            item.midi_data1  = {1'($urandom), note};
         end else if (pick < 84) begin
            item.midi_status = {KIND_CONTROL, chan};
            item.midi_data1  = {1'($urandom), CTRL_ALL_NOTES_OFF};
         end else if (pick < 90) begin
            item.midi_status = {KIND_CONTROL, chan};
         end
      end
      return item;
   endfunction

   // Offers one item, holds it until taken, then records what it should yield.
   task automatic send_item(req_type item);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < req_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      expected_results.push_back(grid_next_result(item));
      if (item.opcode == OPC_READ) read_count++;
      else update_count++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic index, logic [BRIGHT_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_index   <= index;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      if (index == CSR_BRIGHTNESS) cur_brightness = (value > BRIGHT_MAX) ? BRIGHT_MAX : value;
      else cur_display_off = value[0];
   endtask

   task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $error("result item arrived with nothing expected");
            error_count++;
         end else begin
            want = expected_results.pop_front();
            check_field("handled", want.handled, rsp_data.handled);
            check_field("lit", want.lit, rsp_data.lit);
            check_field("red", want.red, rsp_data.red);
            check_field("green", want.green, rsp_data.green);
            check_field("blue", want.blue, rsp_data.blue);
            check_field("brightness_echo", want.brightness_echo, rsp_data.brightness_echo);
            check_field("generation", want.generation, rsp_data.generation);
            if (want.handled) handled_count++;
            if (want.lit) lit_count++;
         end
      end
      rsp_stall <= hold_active || ($urandom_range(99) < rsp_idle_pct);
   end

   // long output hold-off, timed here so the sender keeps pushing meanwhile
   always begin
      @(hold_go);
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_active <= 1'b0;
   end

   task automatic test_note_tracking();
      send_item(make_read(7'd0));
      send_item(make_update({KIND_NOTE_ON, 4'h0}, 8'd64, 8'd127));
      send_item(make_read(7'd0));
      // note-on with zero velocity acts as note-off
      send_item(make_update({KIND_NOTE_ON, 4'h0}, 8'd64, 8'd0));
      send_item(make_read(7'd0));
      // upper data bits are dropped: velocity 0x80 is zero
      send_item(make_update({KIND_NOTE_ON, 4'hF}, 8'hFF, 8'h80));
      send_item(make_update({KIND_NOTE_ON, 4'hF}, 8'hFF, 8'hFF));
      send_item(make_update({KIND_NOTE_ON, 4'h3}, 8'd79, 8'd1));
      send_item(make_read(7'd15));
      send_item(make_update({KIND_NOTE_OFF, 4'h3}, 8'd79, 8'h7F));
      send_item(make_read(7'd15));
      // serpentine: row 1 starts at the right end
      send_item(make_update({KIND_NOTE_ON, 4'h5}, 8'd59, 8'd100));
      send_item(make_read(7'd31));
      send_item(make_read(7'd16));
      send_item(make_update({KIND_NOTE_ON, 4'h0}, 8'd40, 8'h7F));
      send_item(make_read(7'd95));
      send_item(make_read(7'd96));
      send_item(make_read(7'd127));
      wait_idle();
   endtask

   task automatic test_controllers();
      send_item(make_update({KIND_CONTROL, 4'h5}, 8'd123, 8'd0));
      send_item(make_read(7'd31));
      send_item(make_update({KIND_CONTROL, 4'h0}, 8'hFB, 8'hFF));
      send_item(make_read(7'd95));
      send_item(make_update({KIND_CONTROL, 4'h3}, 8'd122, 8'd0));
      send_item(make_update(8'hA0, 8'd64, 8'd64));
      send_item(make_update(8'hFF, 8'hFF, 8'hFF));
      send_item(make_update(8'h00, 8'h00, 8'h00));
      wait_idle();
   endtask

   task automatic test_registers();
      send_item(make_update({KIND_NOTE_ON, 4'h7}, 8'd64, 8'd5));
      wait_idle();
      write_csr(CSR_BRIGHTNESS, 7'd127);
      send_item(make_read(7'd0));
      wait_idle();
      write_csr(CSR_DISPLAY_OFF, 7'h7F);
      write_csr(CSR_BRIGHTNESS, 7'd0);
      send_item(make_read(7'd0));
      wait_idle();
      write_csr(CSR_DISPLAY_OFF, 7'h7E);
      write_csr(CSR_BRIGHTNESS, 7'd97);
      send_item(make_read(7'd0));
      wait_idle();
   endtask

   task automatic test_random_traffic();
      logic [BRIGHT_W-1:0] chunk_brightness [6];
      chunk_brightness = '{7'd96, 7'd127, 7'd0, 7'd1, 7'd97, 7'($urandom)};
      for (int chunk = 0; chunk < 6; chunk++) begin
         case (chunk / 2)
            0: begin req_idle_pct = 12; rsp_idle_pct = 86; end
            1: begin req_idle_pct = 86; rsp_idle_pct = 12; end
            default: begin req_idle_pct = 0; rsp_idle_pct = 0; end
         endcase
         write_csr(CSR_BRIGHTNESS, chunk_brightness[chunk]);
         write_csr(CSR_DISPLAY_OFF, 7'(chunk == 2));
         repeat (CHUNK_ITEMS) send_item(random_item());
         wait_idle();
      end
   endtask

   task automatic test_backpressure();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      -> hold_go;
      repeat (24) send_item(random_item());
      wait_idle();
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_wr_en   = 1'b0;
      csr_index   = CSR_BRIGHTNESS;
      csr_wr_data = '0;
      for (int n = 0; n < NOTE_COUNT; n++) held_channels[n] = '0;
      gen_count       = 1;
      cur_brightness  = BRIGHT_MAX;
      cur_display_off = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_note_tracking();
      test_controllers();
      test_registers();
      test_random_traffic();
      test_backpressure();

      $display("summary: %0d items sent, %0d MIDI updates (%0d applied), %0d pixel reads",
               update_count + read_count, update_count, handled_count, read_count);
      $display("summary: %0d lit pixels seen, generation ended at %0d, %0d mismatches",
               lit_count, gen_count, error_count);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+rtl
rtl/mnlg_pkg.sv
rtl/midi_note_led_grid.sv
test/midi_note_led_grid_test.sv
